// ===== rtl/fslfa_pkg.sv =====
// Package for the fixed-slot free-list allocator.
// Holds operation and status codes, field widths and the slot entry type.
// No dependencies.
package fslfa_pkg;

  // Field widths.
  localparam int OP_W   = 2;
  localparam int SLOT_W = 8;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 9;

  // Largest pool the 8-bit slot field can address.
  localparam int MAX_POOL = 256;

  // Slot count register value after reset.
  localparam logic [CNT_W-1:0] CNT_RESET = 9'd256;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
  localparam logic [OP_W-1:0] OP_REBUILD = 2'd2;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK           = 2'd0;
  localparam logic [ST_W-1:0] ST_NO_SPACE     = 2'd1;
  localparam logic [ST_W-1:0] ST_ALREADY_FREE = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE        = 2'd3;

  // One stored slot: its free mark and its link to the next free slot.
  typedef struct packed {
    logic              free;
    logic [SLOT_W-1:0] link;
  } entry_t;

endpackage

// ===== rtl/fslfa_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module fslfa_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered: data is valid in the cycle after the read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/fslfa_slot_store.sv =====
// Slot entry store: RAM of free marks and links plus per-entry valid bits.
// An entry never written since reset or rebuild reads as its reset value.
// Depends on fslfa_pkg and fslfa_ram.
module fslfa_slot_store #(
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            clear,
  input  logic [fslfa_pkg::CNT_W-1:0]     active,
  input  logic                            rd_en,
  input  logic [AW-1:0]                   rd_addr,
  output fslfa_pkg::entry_t               rd_entry,
  input  logic                            wr_en,
  input  logic [AW-1:0]                   wr_addr,
  input  fslfa_pkg::entry_t               wr_entry
);

  localparam int EW = $bits(fslfa_pkg::entry_t);

  logic [DEPTH-1:0]              vld_r;
  logic [DEPTH-1:0]              vld_nxt;
  logic                          rd_vld_r;
  logic [AW-1:0]                 rd_addr_r;
  logic [EW-1:0]                 ram_rd_data;
  logic [fslfa_pkg::CNT_W-1:0]   rst_idx;
  logic [fslfa_pkg::CNT_W-1:0]   rst_link;
  fslfa_pkg::entry_t             ram_entry;

  fslfa_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  // Valid bits: cleared at reset and rebuild, set by each write.
  always_comb begin
    vld_nxt = vld_r;
    if (clear) begin
      vld_nxt = '0;
    end else if (wr_en) begin
      vld_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Capture the valid bit and address alongside the RAM read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_vld_r  <= vld_r[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // Reset value of an entry: chained to the next index, free inside the pool.
  assign rst_idx   = fslfa_pkg::CNT_W'(rd_addr_r);
  assign rst_link  = rst_idx + fslfa_pkg::CNT_W'(1);
  assign ram_entry = fslfa_pkg::entry_t'(ram_rd_data);

  always_comb begin
    if (rd_vld_r) begin
      rd_entry = ram_entry;
    end else begin
      rd_entry.free = (rst_idx < active);
      rd_entry.link = rst_link[fslfa_pkg::SLOT_W-1:0];
    end
  end

endmodule

// ===== rtl/fixed_slot_free_list_allocator_core.sv =====
// Fixed-slot free-list allocator, top level.
// Depends on fslfa_pkg and fslfa_slot_store.
//
// A pool of fixed-size slots kept as a last-in first-out free list.
// Input channel (in_valid/in_ready) carries one request: allocate, free a
// slot, or rebuild the pool. Output channel (out_valid/out_ready) returns
// one result per request: a status and, for a granted allocation, the slot.
// cfg_wr_en/cfg_wr_data set the pool size; it takes effect at the next
// rebuild, and should be written only while the block is idle.
//
// A request is accepted and its slot entry is read from the entry RAM; once
// the output register is free, the result is formed, registered and the
// entry written back. The RAM read is registered, and no new request is taken
// until the current one is finished. If the receiver stalls, one finished
// result waits in the output register while the next request is still
// accepted; that request then holds until the output register frees. After
// reset the pool holds SLOTS slots (at most 256), all free, and allocations
// return 0, 1, 2 in order. No clearing pass is needed after reset.
module fixed_slot_free_list_allocator_core #(
  parameter int SLOTS = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [fslfa_pkg::CNT_W-1:0]       cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [fslfa_pkg::OP_W-1:0]        in_operation,
  input  logic [fslfa_pkg::SLOT_W-1:0]      in_slot,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fslfa_pkg::ST_W-1:0]        out_status,
  output logic [fslfa_pkg::SLOT_W-1:0]      out_slot_out
);

  localparam int DEPTH = (SLOTS < fslfa_pkg::MAX_POOL) ? SLOTS : fslfa_pkg::MAX_POOL;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [fslfa_pkg::CNT_W-1:0] DEPTH_CNT = fslfa_pkg::CNT_W'(DEPTH);

  // Control and payload registers.
  logic                              busy_r;
  logic                              busy_nxt;
  logic [fslfa_pkg::OP_W-1:0]        op_r;
  logic [fslfa_pkg::SLOT_W-1:0]      slot_r;
  logic [fslfa_pkg::SLOT_W-1:0]      head_r;
  logic [fslfa_pkg::SLOT_W-1:0]      head_nxt;
  logic                              empty_r;
  logic                              empty_nxt;
  logic [fslfa_pkg::CNT_W-1:0]       free_cnt_r;
  logic [fslfa_pkg::CNT_W-1:0]       free_cnt_nxt;
  logic [fslfa_pkg::CNT_W-1:0]       active_r;
  logic [fslfa_pkg::CNT_W-1:0]       active_nxt;
  logic [fslfa_pkg::CNT_W-1:0]       cfg_cnt_r;
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic [fslfa_pkg::ST_W-1:0]        out_status_r;
  logic [fslfa_pkg::ST_W-1:0]        status_nxt;
  logic [fslfa_pkg::SLOT_W-1:0]      out_slot_r;
  logic [fslfa_pkg::SLOT_W-1:0]      grant_nxt;

  // Store interface.
  logic                              accept;
  logic                              done;
  logic                              st_clear;
  logic                              st_wr_en;
  logic [AW-1:0]                     st_rd_addr;
  logic [AW-1:0]                     st_wr_addr;
  fslfa_pkg::entry_t                 st_rd_entry;
  fslfa_pkg::entry_t                 st_wr_entry;
  logic [fslfa_pkg::CNT_W-1:0]       clamp_cnt;

  assign accept   = in_valid && in_ready;
  assign in_ready = !busy_r;
  assign done     = busy_r && (!out_valid_r || out_ready);

  // Pool size limited to the stored depth.
  assign clamp_cnt = (cfg_cnt_r > DEPTH_CNT) ? DEPTH_CNT : cfg_cnt_r;

  // A free reads the named slot; everything else reads the list head.
  assign st_rd_addr = (in_operation == fslfa_pkg::OP_FREE) ? in_slot[AW-1:0] : head_r[AW-1:0];

  fslfa_slot_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (st_clear),
    .active   (active_r),
    .rd_en    (accept),
    .rd_addr  (st_rd_addr),
    .rd_entry (st_rd_entry),
    .wr_en    (st_wr_en),
    .wr_addr  (st_wr_addr),
    .wr_entry (st_wr_entry)
  );

  // Finishing step of a request: decide, update the list, write back the entry.
  always_comb begin
    head_nxt      = head_r;
    empty_nxt     = empty_r;
    free_cnt_nxt  = free_cnt_r;
    active_nxt    = active_r;
    status_nxt    = fslfa_pkg::ST_OK;
    grant_nxt     = '0;
    st_clear      = 1'b0;
    st_wr_en      = 1'b0;
    st_wr_addr    = head_r[AW-1:0];
    st_wr_entry   = '0;
    if (done) begin
      case (op_r)
        fslfa_pkg::OP_ALLOC: begin
          if (empty_r || free_cnt_r == '0 || fslfa_pkg::CNT_W'(head_r) >= DEPTH_CNT) begin
            status_nxt = fslfa_pkg::ST_NO_SPACE;
          end else begin
            grant_nxt    = head_r;
            head_nxt     = st_rd_entry.link;
            free_cnt_nxt = free_cnt_r - fslfa_pkg::CNT_W'(1);
            empty_nxt    = (free_cnt_r == fslfa_pkg::CNT_W'(1));
            st_wr_en     = 1'b1;
            st_wr_addr   = head_r[AW-1:0];
            st_wr_entry  = '0;
          end
        end
        fslfa_pkg::OP_FREE: begin
          if (fslfa_pkg::CNT_W'(slot_r) >= active_r) begin
            status_nxt = fslfa_pkg::ST_RANGE;
          end else if (st_rd_entry.free) begin
            status_nxt = fslfa_pkg::ST_ALREADY_FREE;
          end else begin
            head_nxt          = slot_r;
            free_cnt_nxt      = free_cnt_r + fslfa_pkg::CNT_W'(1);
            empty_nxt         = 1'b0;
            st_wr_en          = 1'b1;
            st_wr_addr        = slot_r[AW-1:0];
            st_wr_entry.free  = 1'b1;
            st_wr_entry.link  = empty_r ? st_rd_entry.link : head_r;
          end
        end
        fslfa_pkg::OP_REBUILD: begin
          st_clear     = 1'b1;
          active_nxt   = clamp_cnt;
          head_nxt     = '0;
          free_cnt_nxt = clamp_cnt;
          empty_nxt    = (clamp_cnt == '0);
        end
        default: begin
          // Unused code: no state change, plain ok result.
        end
      endcase
    end
  end

  // Request tracking and output valid.
  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (done) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
    end
    if (accept) begin
      busy_nxt = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      empty_r     <= 1'b0;
      free_cnt_r  <= DEPTH_CNT;
      active_r    <= DEPTH_CNT;
      cfg_cnt_r   <= fslfa_pkg::CNT_RESET;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      empty_r     <= empty_nxt;
      free_cnt_r  <= free_cnt_nxt;
      active_r    <= active_nxt;
      if (cfg_wr_en) begin
        cfg_cnt_r <= cfg_wr_data;
      end
    end
  end

  // Request payload, held until the request finishes.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_operation;
      slot_r <= in_slot;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (done) begin
      out_status_r <= status_nxt;
      out_slot_r   <= grant_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_slot_out = out_slot_r;

endmodule

// ===== dv/free_list_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the fixed-slot free-list allocator: watches the request,
// result and pool size ports, keeps its own slot table and compares replies in order.
// Depends on fslfa_pkg.
module free_list_checker
  import fslfa_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [ST_W-1:0]   out_status,
  input  logic [SLOT_W-1:0] out_slot_out,
  output int unsigned       outstanding,
  output int unsigned       checked,
  output int unsigned       mismatches
);

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [SLOT_W-1:0] slot;
  } reply_t;

  // The slot field addresses at most 256 slots, whatever the parameter says.
  localparam int POOL_LIMIT = (SLOTS < MAX_POOL) ? SLOTS : MAX_POOL;

  entry_t            slot_table [MAX_POOL];
  logic [SLOT_W-1:0] head_slot;
  logic              list_empty;
  int unsigned       free_slots;
  int unsigned       pool_slots;
  logic [CNT_W-1:0]  size_setting;
  reply_t            expected_replies [$];
  int unsigned       res_total;
  int unsigned       fail_total;

  // Mark every slot of the active pool free and chain them in index order.
  task automatic rebuild_pool();
    int unsigned n;
    n = (size_setting > POOL_LIMIT) ? POOL_LIMIT : size_setting;
    pool_slots = n;
    for (int i = 0; i < MAX_POOL; i++) begin
      slot_table[i].link = SLOT_W'(i + 1);
      slot_table[i].free = (i < n);
    end
    head_slot  = '0;
    free_slots = n;
    list_empty = (n == 0);
  endtask

  // Work out the reply to one request and advance the slot table.
  task automatic apply_request(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                               output reply_t reply);
    reply.status = ST_OK;
    reply.slot   = '0;
    case (op)
      OP_ALLOC: begin
        if (list_empty || free_slots == 0) begin
          reply.status = ST_NO_SPACE;
        end else begin
          // Pop the head; the granted slot's link is cleared.
          reply.slot = head_slot;
          head_slot = slot_table[reply.slot].link;
          slot_table[reply.slot].link = '0;
          slot_table[reply.slot].free = 1'b0;
          free_slots--;
          list_empty = (free_slots == 0);
        end
      end
      OP_FREE: begin
        if (slot >= pool_slots) begin
          reply.status = ST_RANGE;
        end else if (slot_table[slot].free) begin
          reply.status = ST_ALREADY_FREE;
        end else begin
          // Push as new head; an empty list leaves the link untouched.
          if (!list_empty) slot_table[slot].link = head_slot;
          head_slot = slot;
          slot_table[slot].free = 1'b1;
          free_slots++;
          list_empty = 1'b0;
        end
      end
      OP_REBUILD: begin
        rebuild_pool();
      end
      default: begin
      end
    endcase
  endtask

  // A reply never leaves in the cycle its request is taken, so the result of an
  // edge is checked before the request of the same edge is predicted.
  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      size_setting = CNT_RESET;
      rebuild_pool();
      expected_replies.delete();
    end else begin
      if (out_valid && out_ready) begin
        res_total++;
        if (expected_replies.size() == 0) begin
          fail_total++;
          $display("%0t: result with no request waiting, expected none, got status %0d slot %0d",
                   $time, out_status, out_slot_out);
        end else begin
          want = expected_replies.pop_front();
          if (out_status !== want.status) begin
            fail_total++;
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_status);
          end
          if (out_slot_out !== want.slot) begin
            fail_total++;
            $display("%0t: slot_out mismatch, expected %0d, got %0d",
                     $time, want.slot, out_slot_out);
          end
        end
      end
      if (cfg_wr_en) size_setting = cfg_wr_data;
      if (in_valid && in_ready) begin
        apply_request(in_operation, in_slot, want);
        expected_replies.push_back(want);
      end
    end
    outstanding <= expected_replies.size();
    checked     <= res_total;
    mismatches  <= fail_total;
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the fixed-slot free-list allocator: clock, reset, request and
// pool size stimulus, result back-pressure and the verdict.
// Depends on fslfa_pkg, fixed_slot_free_list_allocator_core and free_list_checker.
module tb_top;
  import fslfa_pkg::*;

  localparam int POOL_SLOTS = 256;
  localparam int RANDOM_REQUESTS = 1600;
  localparam int TIMEOUT_NS = 4_000_000;
  localparam int END_WAIT_LIMIT = 5000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [CNT_W-1:0] EDGE_SIZES [6] = '{9'd256, 9'd1, 9'd511, 9'd0, 9'd2, 9'd257};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [CNT_W-1:0]  cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   in_operation = OP_ALLOC;
  logic [SLOT_W-1:0] in_slot = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ST_W-1:0]   out_status;
  logic [SLOT_W-1:0] out_slot_out;

  int unsigned outstanding;
  int unsigned checked;
  int unsigned mismatches;

  bit          no_idle = 1'b0;
  int unsigned stall_left = 0;
  int unsigned op_sent [4];
  int unsigned total_sent = 0;
  int unsigned sizes_tried = 0;

  always #2 clk = ~clk;

  fixed_slot_free_list_allocator_core #(
    .SLOTS(POOL_SLOTS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_operation(in_operation),
    .in_slot     (in_slot),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_slot_out(out_slot_out)
  );

  free_list_checker #(
    .SLOTS(POOL_SLOTS)
  ) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_operation(in_operation),
    .in_slot     (in_slot),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_slot_out(out_slot_out),
    .outstanding (outstanding),
    .checked     (checked),
    .mismatches  (mismatches)
  );

  // Gap length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result back-pressure: random stalls, none started while a gap-free stretch runs.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Present one request after a random gap and hold it until it is taken.
  task automatic issue_request(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_slot      <= slot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    op_sent[op]++;
    total_sent++;
  endtask

  // Stop sending and wait until every reply is back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Change the pool size while the block is idle.
  task automatic set_pool_size(input logic [CNT_W-1:0] value);
    drain_results();
    repeat (3) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sizes_tried++;
  endtask

  function automatic logic [CNT_W-1:0] pick_pool_size(input int unsigned phase);
    int unsigned r;
    if (phase < 6) return EDGE_SIZES[phase];
    r = $urandom_range(0, 99);
    if (r < 60) return CNT_W'($urandom_range(1, 24));
    if (r < 75) return CNT_W'($urandom_range(25, 255));
    if (r < 85) return CNT_W'(POOL_SLOTS);
    if (r < 92) return CNT_W'($urandom_range(257, 511));
    if (r < 95) return '0;
    return CNT_W'(1);
  endfunction

  // Alternate fill and drain bursts so the list empties, refills and gets
  // reordered, with a sprinkling of bad frees, unused codes and rebuilds.
  task automatic run_traffic(input int unsigned pool, input int unsigned count);
    bit                filling;
    int unsigned       burst;
    int unsigned       r;
    logic [SLOT_W-1:0] s;
    logic [SLOT_W-1:0] beyond;
    filling = 1'b1;
    burst = $urandom_range(1, 2 * pool + 4);
    for (int unsigned k = 0; k < count; k++) begin
      if (burst == 0) begin
        filling = !filling;
        burst = $urandom_range(1, 2 * pool + 4);
      end
      burst--;
      s = (pool == 0) ? SLOT_W'($urandom) : SLOT_W'($urandom_range(0, pool - 1));
      beyond = (pool >= POOL_SLOTS) ? SLOT_W'($urandom) : SLOT_W'($urandom_range(pool, 255));
      r = $urandom_range(0, 99);
      if (r < 3) issue_request(OP_UNUSED, SLOT_W'($urandom));
      else if (r < 6) issue_request(OP_FREE, beyond);
      else if (r < 7) issue_request(OP_REBUILD, SLOT_W'($urandom));
      else if (r < 9) issue_request(OP_FREE, SLOT_W'($urandom));
      else if ((r < 80) == filling) issue_request(OP_ALLOC, SLOT_W'($urandom));
      else issue_request(OP_FREE, s);
      if ($urandom_range(0, 299) == 0) drain_results();
    end
  endtask

  initial begin
    logic [CNT_W-1:0] size;
    int unsigned      pool;
    int unsigned      phase;
    int unsigned      directed_sent;
    int unsigned      wait_cycles;
    int unsigned      n_req;
    int unsigned      remaining;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full pool after reset: grants come out in index order.
    repeat (3) issue_request(OP_ALLOC, '0);
    // Return one slot, free it again, free the top slot, which is still free, and return slot 0.
    issue_request(OP_FREE, 8'd1);
    issue_request(OP_FREE, 8'd1);
    issue_request(OP_FREE, 8'd255);
    issue_request(OP_FREE, 8'd0);
    // Last freed comes back first; the slot field is ignored here.
    repeat (3) issue_request(OP_ALLOC, 8'hFF);
    issue_request(OP_UNUSED, 8'hAA);
    issue_request(OP_UNUSED, 8'h55);
    issue_request(OP_REBUILD, 8'h0F);
    issue_request(OP_ALLOC, '0);

    // Single-slot pool; the new size only counts from the rebuild on.
    set_pool_size(9'd1);
    issue_request(OP_ALLOC, '0);
    issue_request(OP_REBUILD, '0);
    issue_request(OP_ALLOC, '0);
    issue_request(OP_ALLOC, '0);
    issue_request(OP_FREE, 8'd1);
    issue_request(OP_FREE, 8'd255);
    issue_request(OP_FREE, 8'd0);
    issue_request(OP_FREE, 8'd0);

    // Empty pool: nothing to grant and every slot is out of range.
    set_pool_size(9'd0);
    issue_request(OP_REBUILD, '0);
    issue_request(OP_ALLOC, '0);
    issue_request(OP_FREE, 8'd0);
    directed_sent = total_sent;

    // Random phases, each with its own pool size; the last one is cut to the budget.
    phase = 0;
    while (total_sent < directed_sent + RANDOM_REQUESTS) begin
      size = pick_pool_size(phase);
      set_pool_size(size);
      pool = (size > POOL_SLOTS) ? POOL_SLOTS : size;
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 4)) issue_request(OP_ALLOC, SLOT_W'($urandom));
      issue_request(OP_REBUILD, SLOT_W'($urandom));
      no_idle <= ($urandom_range(0, 4) == 0);
      n_req = (pool > 32) ? $urandom_range(200, 500) : $urandom_range(40, 160);
      remaining = (total_sent < directed_sent + RANDOM_REQUESTS) ?
                  directed_sent + RANDOM_REQUESTS - total_sent : 0;
      if (n_req > remaining) n_req = remaining;
      run_traffic(pool, n_req);
      no_idle <= 1'b0;
      phase++;
    end

    // Let the last replies come back, within a bound.
    in_valid <= 1'b0;
    wait_cycles = 0;
    @(posedge clk);
    while (outstanding != 0 && wait_cycles < END_WAIT_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (4) @(posedge clk);
    if (outstanding != 0)
      $display("%0t: %0d expected results never arrived", $time, outstanding);

    $display("Sent %0d requests: %0d allocate, %0d free, %0d rebuild, %0d unused code.",
             total_sent, op_sent[OP_ALLOC], op_sent[OP_FREE], op_sent[OP_REBUILD],
             op_sent[OP_UNUSED]);
    $display("Compared %0d results across %0d pool size settings, %0d field mismatches.",
             checked, sizes_tried, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS fixed_slot_free_list_allocator_core");
    end else begin
      $display("FAIL fixed_slot_free_list_allocator_core");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout", $time);
    $display("FAIL fixed_slot_free_list_allocator_core");
    $finish;
  end

endmodule
